[rtl/ramp_pwm_sample_averager_unit_macros.svh]
// ----------------------------------------------------------------------------
// ramp_pwm_sample_averager_unit_macros.svh
// Assertion helpers for the ramp PWM sample averager.
// ----------------------------------------------------------------------------
`ifndef RAMP_PWM_SAMPLE_AVERAGER_UNIT_MACROS_SVH
`define RAMP_PWM_SAMPLE_AVERAGER_UNIT_MACROS_SVH

// Checked on every rising edge, masked while reset is asserted.
`define RPSA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define RPSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[rtl/rpsa_pkg.sv]
// ----------------------------------------------------------------------------
// rpsa_pkg
// Shared types and constants of the ramp PWM sample averager.
// ----------------------------------------------------------------------------
package rpsa_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned RING_DEPTH_DEF  = 4;
  localparam int unsigned SAMPLE_BITS_DEF = 10;

  // Fixed field widths
  localparam int unsigned DUTY_W     = 10;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned LEVEL_W    = 5;
  localparam int unsigned STEP_W     = 7;
  localparam int unsigned INTV_W     = 8;
  localparam int unsigned PROD_W     = LEVEL_W + STEP_W;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [DUTY_W-1:0] DUTY_MAX = {DUTY_W{1'b1}};

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_1     = 8'h31;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
  localparam logic [CHAR_W-1:0] CMD_PRINT  = 8'h70;
  localparam logic [CHAR_W-1:0] CMD_AUTO   = 8'h61;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTV = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTV = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_STEP   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_TOP    = 8'd3;

  // Register reset values
  localparam logic [INTV_W-1:0]  SAMPLE_INTV_RST = 8'd5;
  localparam logic [INTV_W-1:0]  REPORT_INTV_RST = 8'd20;
  localparam logic [STEP_W-1:0]  DUTY_STEP_RST   = 7'd63;
  localparam logic [LEVEL_W-1:0] RAMP_TOP_RST    = 5'd16;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_BYTE = 1'b1
  } action_e;

  typedef enum logic {
    KIND_DUTY = 1'b0,
    KIND_CHAR = 1'b1
  } kind_e;

  // Job handed from the command logic to the result serializer
  typedef struct packed {
    logic load;       // new job this cycle
    logic has_duty;   // job opens with a duty update
    logic has_chars;  // job sends a value as characters plus tab
    logic from_sum;   // value is the ring average, not the raw sample
  } job_ctrl_t;

endpackage

[rtl/rpsa_in_if.sv]
// ----------------------------------------------------------------------------
// rpsa_in_if
// Input channel: timer ticks and received bytes with the current sample.
// ----------------------------------------------------------------------------
interface rpsa_in_if #(
  parameter int unsigned SAMPLE_BITS = rpsa_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [7:0]             rx_byte;
  logic [SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, action, rx_byte, adc_sample, input ready);
  modport sink   (input valid, action, rx_byte, adc_sample, output ready);
endinterface

[rtl/rpsa_out_if.sv]
// ----------------------------------------------------------------------------
// rpsa_out_if
// Result channel: duty updates and transmit characters.
// ----------------------------------------------------------------------------
interface rpsa_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [9:0] duty;
  logic [7:0] tx_char;
  logic       last;

  modport source (output valid, result_kind, duty, tx_char, last, input ready);
  modport sink   (input valid, result_kind, duty, tx_char, last, output ready);
endinterface

[rtl/rpsa_serializer.sv]
// ----------------------------------------------------------------------------
// rpsa_serializer
// Holds one job and plays it out as result transactions, one per cycle while out_o.ready is high.
// ----------------------------------------------------------------------------
module rpsa_serializer #(
  parameter int unsigned SAMPLE_BITS = rpsa_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned RING_DEPTH  = rpsa_pkg::RING_DEPTH_DEF,
  parameter int unsigned SUM_W       = SAMPLE_BITS + $clog2(RING_DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rpsa_pkg::job_ctrl_t           ctrl_i,
  input  logic [rpsa_pkg::DUTY_W-1:0]   duty_i,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  input  logic [SUM_W-1:0]              sum_i,
  output logic                          free_o,
  rpsa_out_if.source                    out_o
);
  import rpsa_pkg::*;

  // Floor division by RING_DEPTH as multiply by rounded-up reciprocal
  localparam int unsigned    DIV_SH   = SUM_W + $clog2(RING_DEPTH);
  localparam longint unsigned DIV_M_L =
    ((longint'(1) << DIV_SH) + RING_DEPTH - 1) / RING_DEPTH;
  localparam logic [DIV_SH-1:0] DIV_M = DIV_SH'(DIV_M_L);
  localparam int unsigned    MUL_W    = SUM_W + DIV_SH;
  localparam int unsigned    CNT_W    = $clog2(SAMPLE_BITS + 2);
  localparam logic [CNT_W-1:0] NCHAR  = CNT_W'(SAMPLE_BITS + 1);
  localparam logic [CNT_W-1:0] ONE    = CNT_W'(1);

  logic                   busy_q, busy_d;
  logic                   duty_pend_q, duty_pend_d;
  logic                   div_pend_q, div_pend_d;
  logic [CNT_W-1:0]       left_q, left_d;
  logic [DUTY_W-1:0]      duty_q, duty_d;
  logic [SAMPLE_BITS-1:0] val_q, val_d;
  logic [MUL_W-1:0]       div_prod;
  logic [SAMPLE_BITS-1:0] quot;
  logic                   take;
  logic                   is_last;
  logic                   done;

  assign div_prod = MUL_W'(sum_i) * MUL_W'(DIV_M);
  assign quot     = div_prod[DIV_SH +: SAMPLE_BITS];

  assign take    = busy_q && out_o.ready;
  assign is_last = duty_pend_q ? (left_q == '0) : (left_q == ONE);
  assign done    = take && is_last;
  assign free_o  = !busy_q || done;

  always_comb begin
    busy_d      = busy_q;
    duty_pend_d = duty_pend_q;
    div_pend_d  = div_pend_q;
    left_d      = left_q;
    duty_d      = duty_q;
    val_d       = val_q;
    if (ctrl_i.load) begin
      busy_d      = 1'b1;
      duty_pend_d = ctrl_i.has_duty;
      div_pend_d  = ctrl_i.from_sum;
      left_d      = ctrl_i.has_chars ? NCHAR : '0;
      duty_d      = duty_i;
      val_d       = sample_i;
    end else begin
      // average is ready before the duty slot has gone out
      if (div_pend_q) begin
        val_d      = quot;
        div_pend_d = 1'b0;
      end
      if (take) begin
        if (done) begin
          busy_d = 1'b0;
        end
        if (duty_pend_q) begin
          duty_pend_d = 1'b0;
        end else begin
          left_d = left_q - ONE;
          val_d  = val_q << 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      duty_pend_q <= 1'b0;
      div_pend_q  <= 1'b0;
      left_q      <= '0;
    end else begin
      busy_q      <= busy_d;
      duty_pend_q <= duty_pend_d;
      div_pend_q  <= div_pend_d;
      left_q      <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    duty_q <= duty_d;
    val_q  <= val_d;
  end

  always_comb begin
    out_o.valid = busy_q;
    out_o.last  = is_last;
    if (duty_pend_q) begin
      out_o.result_kind = KIND_DUTY;
      out_o.duty        = duty_q;
      out_o.tx_char     = CHAR_NONE;
    end else begin
      out_o.result_kind = KIND_CHAR;
      out_o.duty        = '0;
      if (left_q == ONE) begin
        out_o.tx_char = CHAR_TAB;
      end else begin
        out_o.tx_char = val_q[SAMPLE_BITS-1] ? CHAR_1 : CHAR_0;
      end
    end
  end

endmodule

[rtl/ramp_pwm_sample_averager_unit.sv]
// ----------------------------------------------------------------------------
// ramp_pwm_sample_averager_unit
// Triangle-ramp PWM duty generator with an averaged sample reporter.
//
// in_i  : one transaction per timer tick (action 0) or received byte
//         (action 1), each carrying the current converter sample.
// out_o : result transactions; a tick gives a duty update, followed in auto
//         mode by SAMPLE_BITS '0'/'1' characters and a tab when a report is
//         due; a 'p' byte gives the characters of the current sample; other
//         bytes give none. last marks the final result of each input.
// cfg_* : register writes, one per cycle, only while the block is idle.
// Latency: the first result is valid the cycle after the input is accepted.
// Throughput: one input per cycle while each yields at most one result and
//   out_o.ready is high; an input with more results holds the serializer
//   until its last result is taken (at most SAMPLE_BITS + 2), as out_o moves
//   one transaction per cycle; in_i.ready rises in the cycle that result is taken.
// Reset: ramp at level 0 climbing, auto mode off, counters and the sample
//   ring cleared, registers at their defaults; no results pending.
// Receiver stall: the pending result holds; new input waits on ready.
// ----------------------------------------------------------------------------
`include "ramp_pwm_sample_averager_unit_macros.svh"

module ramp_pwm_sample_averager_unit #(
  parameter int unsigned RING_DEPTH  = rpsa_pkg::RING_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = rpsa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rpsa_in_if.sink                           in_i,
  rpsa_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [rpsa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rpsa_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import rpsa_pkg::*;

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned SUM_W = SAMPLE_BITS + IDX_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

  // Configuration registers
  logic [INTV_W-1:0]  samp_intv_q;
  logic [INTV_W-1:0]  rep_intv_q;
  logic [STEP_W-1:0]  step_q;
  logic [LEVEL_W-1:0] top_q;

  // Block state
  logic [LEVEL_W-1:0]     level_q, level_d;
  logic                   down_q, down_d;
  logic                   auto_q, auto_d;
  logic [INTV_W-1:0]      samp_cnt_q, samp_cnt_d;
  logic [INTV_W-1:0]      rep_cnt_q, rep_cnt_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] ring_q [RING_DEPTH];

  logic                   accept;
  logic                   tick;
  logic                   print_cmd;
  logic                   auto_cmd;
  logic [SAMPLE_BITS-1:0] sample;
  logic [PROD_W-1:0]      prod;
  logic [DUTY_W-1:0]      duty;
  logic [INTV_W-1:0]      samp_inc;
  logic [INTV_W-1:0]      rep_inc;
  logic                   store;
  logic                   report;
  logic [IDX_W-1:0]       idx_nxt;
  job_ctrl_t              job;
  logic                   ser_free;

  assign accept    = in_i.valid && in_i.ready;
  assign tick      = accept && (in_i.action == ACT_TICK);
  assign print_cmd = accept && (in_i.action == ACT_BYTE) && (in_i.rx_byte == CMD_PRINT);
  assign auto_cmd  = accept && (in_i.action == ACT_BYTE) && (in_i.rx_byte == CMD_AUTO);
  assign sample    = in_i.adc_sample;

  // Duty from the level before this tick's ramp step
  assign prod = PROD_W'(level_q) * PROD_W'(step_q);
  assign duty = (prod > PROD_W'(DUTY_MAX)) ? DUTY_MAX : prod[DUTY_W-1:0];

  // Ramp: climb to ramp_top, fall back to zero
  always_comb begin
    level_d = level_q;
    down_d  = down_q;
    if (tick) begin
      if (!down_q) begin
        level_d = level_q + LEVEL_W'(1);
        if (level_d >= top_q) begin
          down_d = 1'b1;
        end
        if (level_d == '0) begin
          down_d = 1'b0;
        end
      end else begin
        level_d = level_q - LEVEL_W'(1);
        if (level_d == '0) begin
          down_d = 1'b0;
        end
      end
    end
  end

  assign auto_d = auto_cmd ? !auto_q : auto_q;

  // Interval counters run only on auto-mode ticks
  assign samp_inc = samp_cnt_q + INTV_W'(1);
  assign rep_inc  = rep_cnt_q + INTV_W'(1);
  assign store    = tick && auto_q && (samp_inc >= samp_intv_q);
  assign report   = tick && auto_q && (rep_inc >= rep_intv_q);

  always_comb begin
    samp_cnt_d = samp_cnt_q;
    rep_cnt_d  = rep_cnt_q;
    if (tick && auto_q) begin
      samp_cnt_d = store ? '0 : samp_inc;
      rep_cnt_d  = report ? '0 : rep_inc;
    end
  end

  // Ring index advances first, then the sample lands there; the running
  // sum swaps the evicted entry for the new sample.
  assign idx_nxt = (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
  assign idx_d   = store ? idx_nxt : idx_q;
  assign sum_d   = store ? (sum_q - SUM_W'(ring_q[idx_nxt]) + SUM_W'(sample)) : sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= '0;
      down_q     <= 1'b0;
      auto_q     <= 1'b0;
      samp_cnt_q <= '0;
      rep_cnt_q  <= '0;
      idx_q      <= '0;
      sum_q      <= '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      level_q    <= level_d;
      down_q     <= down_d;
      auto_q     <= auto_d;
      samp_cnt_q <= samp_cnt_d;
      rep_cnt_q  <= rep_cnt_d;
      idx_q      <= idx_d;
      sum_q      <= sum_d;
      if (store) begin
        ring_q[idx_nxt] <= sample;
      end
    end
  end

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_intv_q <= SAMPLE_INTV_RST;
      rep_intv_q  <= REPORT_INTV_RST;
      step_q      <= DUTY_STEP_RST;
      top_q       <= RAMP_TOP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SAMPLE_INTV: samp_intv_q <= cfg_data_i[INTV_W-1:0];
        REG_REPORT_INTV: rep_intv_q  <= cfg_data_i[INTV_W-1:0];
        REG_DUTY_STEP:   step_q      <= cfg_data_i[STEP_W-1:0];
        REG_RAMP_TOP:    top_q       <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Job for the serializer; the average is taken from sum_q in the cycle after the job loads
  assign job.load      = tick || print_cmd;
  assign job.has_duty  = tick;
  assign job.has_chars = print_cmd || report;
  assign job.from_sum  = report;

  rpsa_serializer #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .RING_DEPTH  (RING_DEPTH),
    .SUM_W       (SUM_W)
  ) u_ser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (job),
    .duty_i   (duty),
    .sample_i (sample),
    .sum_i    (sum_q),
    .free_o   (ser_free),
    .out_o    (out_o)
  );

  assign in_i.ready = ser_free;

  // Assertions
  `RPSA_ASSERT(a_tick_duty_next, clk_i, rst_ni, (tick |=> (out_o.valid && out_o.result_kind == KIND_DUTY)), "tick did not yield a duty result")
  `RPSA_ASSERT(a_last_frees_input, clk_i, rst_ni, ((out_o.valid && out_o.ready && out_o.last) |-> in_i.ready), "input stalled after final result")
  `RPSA_ASSERT_ALWAYS(a_ring_idx_range, clk_i, (idx_q <= IDX_LAST), "ring index out of range")

endmodule
